@@ design/smf_pkg.sv @@
// shared constants, codes and control types for the sliding median filter
package smf_pkg;

    localparam int WINDOW = 5;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int DATA_W = 32;

    // first fill count at which the result comes from the sorted window
    localparam int MIN_SORT_FILL = 3;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_SEED   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic hit;
        logic out_blocked;
    } dp_status_t;

endpackage

@@ design/smf_if.sv @@
// valid/ready channel interfaces for samples in and medians out
interface smf_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      opcode;
    logic signed [smf_pkg::DATA_W-1:0] sample_value;

    modport source (output valid, output opcode, output sample_value, input ready);
    modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

interface smf_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [smf_pkg::DATA_W-1:0] median_out;
    logic                            window_full;

    modport source (output valid, output median_out, output window_full, input ready);
    modport sink   (input valid, input median_out, input window_full, output ready);
endinterface

@@ design/smf_ctrl.sv @@
// controller state machine: accept, rank scan, result hand-off
module smf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  smf_pkg::dp_status_t status,
    output smf_pkg::ctrl_cmd_t  cmd
);
    import smf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.need_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (status.hit)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_out = !status.out_blocked;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/smf_datapath.sv @@
// window store, rank counter and output register
module smf_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smf_pkg::ctrl_cmd_t                 cmd,
    output smf_pkg::dp_status_t                status,
    input  logic [1:0]                         opcode,
    input  logic signed [smf_pkg::DATA_W-1:0]  sample_value,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic signed [smf_pkg::DATA_W-1:0]  median_out,
    output logic                               window_full
);
    import smf_pkg::*;

    logic signed [DATA_W-1:0] slot_reg  [WINDOW];
    logic signed [DATA_W-1:0] slot_next [WINDOW];
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic [IDX_W-1:0]         oldest_reg;
    logic [IDX_W-1:0]         oldest_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         target_reg;
    logic [CNT_W-1:0]         target_next;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [DATA_W-1:0] result_reg;
    logic signed [DATA_W-1:0] result_next;
    logic signed [DATA_W-1:0] median_reg;
    logic                     full_reg;
    logic                     out_valid_reg;
    logic                     need_scan;
    logic                     is_full;
    logic [CNT_W-1:0]         fill_inc;
    logic signed [DATA_W-1:0] cand;
    logic [WINDOW-1:0]        below;
    logic [CNT_W-1:0]         rank;

    assign is_full  = (fill_reg >= CNT_W'(WINDOW));
    assign fill_inc = fill_reg + CNT_W'(1);

    // decode of the incoming transaction against the current fill
    always_comb
    begin
        for (int j = 0; j < WINDOW; j++)
        begin
            slot_next[j] = slot_reg[j];
        end
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        target_next = target_reg;
        result_next = '0;
        need_scan   = 1'b0;
        unique case (op_t'(opcode))
            OP_SAMPLE:
            begin
                result_next = sample_value;
                if (!is_full)
                begin
                    slot_next[fill_reg[IDX_W-1:0]] = sample_value;
                    fill_next   = fill_inc;
                    count_next  = fill_inc;
                    target_next = fill_inc >> 1;
                    need_scan   = (fill_inc >= CNT_W'(MIN_SORT_FILL));
                end
                else
                begin
                    slot_next[oldest_reg] = sample_value;
                    oldest_next = (oldest_reg >= IDX_W'(WINDOW - 1)) ?
                                  '0 : oldest_reg + IDX_W'(1);
                    count_next  = CNT_W'(WINDOW);
                    target_next = CNT_W'(WINDOW / 2);
                    need_scan   = 1'b1;
                end
            end
            OP_SEED:
            begin
                for (int j = 0; j < WINDOW; j++)
                begin
                    slot_next[j] = sample_value;
                end
                fill_next   = CNT_W'(WINDOW);
                oldest_next = '0;
                result_next = sample_value;
            end
            OP_CLEAR:
            begin
                for (int j = 0; j < WINDOW; j++)
                begin
                    slot_next[j] = '0;
                end
                fill_next   = '0;
                oldest_next = '0;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    // stable rank of the current candidate slot among the filled slots
    assign cand = slot_reg[idx_reg];
    always_comb
    begin
        for (int j = 0; j < WINDOW; j++)
        begin
            below[j] = (CNT_W'(j) < count_reg) &&
                       ((slot_reg[j] < cand) ||
                        ((slot_reg[j] == cand) && (IDX_W'(j) < idx_reg)));
        end
    end
    assign rank = CNT_W'($countones(below));

    // window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                slot_reg[j] <= '0;
            end
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else if (cmd.accept)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                slot_reg[j] <= slot_next[j];
            end
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
        end
    end

    // scan bookkeeping and result capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            count_reg  <= count_next;
            target_reg <= target_next;
            idx_reg    <= '0;
            result_reg <= result_next;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (rank == target_reg)
            begin
                result_reg <= cand;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            median_reg <= result_reg;
            full_reg   <= is_full;
        end
    end

    assign status.need_scan   = need_scan;
    assign status.hit         = (rank == target_reg);
    assign status.out_blocked = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign median_out  = median_reg;
    assign window_full = full_reg;

endmodule

@@ design/sliding_median_filter.sv @@
// top level of the sliding-window median filter
//
// sample_ch carries one transaction per item: an opcode (sample, seed,
// clear, or the spare code that changes nothing) and a signed 32-bit value.
// result_ch returns exactly one transaction per item: the median or echoed
// value and a flag telling whether the window holds WINDOW samples.
// The block works on one item at a time. A seed, clear, spare code or early
// sample goes from acceptance to the finish state, which loads the result
// into the output register and returns to idle for the next item. A sorted
// sample first runs a rank scan, one slot per cycle from slot 0 up to the
// selected slot among the n filled slots, before the finish state.
// The result sits in an output register, so the next item is accepted
// while a finished result still waits on result_ch.
// If the receiver stalls, the following result waits in the datapath while
// the controller holds until the output register frees up, and no further
// item is taken.
// Reset empties the window, zeroes the store and drops any pending result.
module sliding_median_filter (
    input  logic      clk,
    input  logic      rst_n,
    smf_in_if.sink    sample_ch,
    smf_out_if.source result_ch
);
    import smf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing
    smf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_ready (sample_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // window store and selection
    smf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (sample_ch.opcode),
        .sample_value (sample_ch.sample_value),
        .out_ready    (result_ch.ready),
        .out_valid    (result_ch.valid),
        .median_out   (result_ch.median_out),
        .window_full  (result_ch.window_full)
    );

endmodule
